>>> design/smig_pkg.sv
// Shared types and constants for the sphere mesh index generator.
// No dependencies.
package smig_pkg;

  localparam int unsigned IdxW = 20;
  localparam int unsigned CfgW = 11;

  localparam logic [CfgW-1:0] LonReset = CfgW'(32);
  localparam logic [CfgW-1:0] LatReset = CfgW'(16);

  typedef enum logic [0:0] {
    REG_LONGITUDE = 1'b0,
    REG_LATITUDE  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [IdxW-1:0] index_first;
    logic [IdxW-1:0] index_second;
    logic [IdxW-1:0] index_third;
    logic            last_triangle;
  } tri_t;

endpackage

>>> design/smig_req_if.sv
// Request channel: one item per triangle, with the restart flag.
// No dependencies.
interface smig_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

>>> design/smig_rsp_if.sv
// Result channel: three vertex indices and the last-triangle flag.
// Depends on smig_pkg for the index width.
interface smig_rsp_if
  import smig_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] index_first;
  logic [IdxW-1:0] index_second;
  logic [IdxW-1:0] index_third;
  logic            last_triangle;

  modport source (output valid, output index_first, output index_second,
                  output index_third, output last_triangle, input ready);
  modport sink   (input valid, input index_first, input index_second,
                  input index_third, input last_triangle, output ready);
endinterface

>>> design/smig_out_buf.sv
// Two-entry output buffer (result register plus skid register).
// Depends on smig_pkg (tri_t).
module smig_out_buf
  import smig_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  tri_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output tri_t out_data_o
);

  logic main_valid_q, main_valid_d;
  logic skid_valid_q, skid_valid_d;
  tri_t main_q, main_d;
  tri_t skid_q, skid_d;
  logic in_fire;
  logic main_free;

  assign in_ready_o  = ~skid_valid_q;
  assign in_fire     = in_valid_i & ~skid_valid_q;
  assign main_free   = ~main_valid_q | out_ready_i;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (main_free) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = in_data_i;
        main_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = in_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

>>> design/sphere_mesh_index_generator.sv
// Top level of the sphere mesh index generator: sequence counters and
// triangle index logic. Depends on smig_pkg, smig_req_if, smig_rsp_if
// and smig_out_buf.
//
// Usage: every item accepted on req_i yields exactly one triangle on
// rsp_o, in mesh order: north cap, bands (two triangles per column),
// south cap. last_triangle marks the final south cap triangle; the next
// item starts over at the first north cap triangle. restart = 1 on an
// item starts over before that item's triangle is produced.
// Configuration: cfg_we_i writes longitude (index 0) or latitude
// (index 1) counts; any write restarts the sequence. Write only while
// the block is idle. Out-of-range counts are clamped.
// Output: each triangle is registered in the output buffer that drives rsp_o.
// Throughput: one item per cycle while req_i.ready is high, set by the
// combinational counter update (ring base add plus column/band compares).
// Stall: a two-entry output buffer holds results; req_i.ready drops only
// when both entries are full, so one more item is taken after a stall.
// Reset: counts return to 32 and 16, the sequence to its first triangle,
// and the output buffer empties.
module sphere_mesh_index_generator
  import smig_pkg::*;
#(
  parameter int unsigned MAX_LONGITUDE = 1024,
  parameter int unsigned MAX_LATITUDE  = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  cfg_reg_e        cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  smig_req_if.sink        req_i,
  smig_rsp_if.source      rsp_o
);

  localparam int unsigned LonW  = $clog2(MAX_LONGITUDE + 1);
  localparam int unsigned ColW  = $clog2(MAX_LONGITUDE);
  localparam int unsigned LatW  = $clog2(MAX_LATITUDE + 1);
  localparam int unsigned BandW = $clog2(MAX_LATITUDE);

  logic [CfgW-1:0]  lon_cfg_q, lat_cfg_q;
  logic [BandW-1:0] band_q, band_d, band_cur;
  logic [ColW-1:0]  col_q, col_d, col_cur;
  logic             half_q, half_d, half_cur;
  logic [IdxW-1:0]  rb_q, rb_d, rb_cur;

  logic [LonW-1:0]  lon_eff;
  logic [LatW-1:0]  lat_eff;
  logic [BandW-1:0] south_band;
  logic [LonW-1:0]  col_inc;
  logic [ColW-1:0]  col_nxt;
  logic             at_row_end;
  logic             restart_eff;
  logic             col_done;
  logic             acc;
  logic             buf_ready;
  logic [IdxW-1:0]  lon_idx, col_idx, nxt_idx, down;
  tri_t             tri_d, tri_out;

  always_comb begin
    logic [31:0] lon_w;
    logic [31:0] lat_w;
    lon_w = 32'(lon_cfg_q);
    lat_w = 32'(lat_cfg_q);
    if (lon_w < 32'd3) begin
      lon_eff = LonW'(3);
    end else if (lon_w > 32'(MAX_LONGITUDE)) begin
      lon_eff = LonW'(MAX_LONGITUDE);
    end else begin
      lon_eff = LonW'(lon_w);
    end
    if (lat_w < 32'd2) begin
      lat_eff = LatW'(2);
    end else if (lat_w > 32'(MAX_LATITUDE)) begin
      lat_eff = LatW'(MAX_LATITUDE);
    end else begin
      lat_eff = LatW'(lat_w);
    end
  end

  assign south_band = BandW'(lat_eff - LatW'(1));
  assign acc        = req_i.valid & buf_ready;
  assign req_i.ready = buf_ready;

  assign restart_eff = req_i.restart | (band_q > south_band) |
                       (LonW'(col_q) >= lon_eff);
  assign band_cur = restart_eff ? '0 : band_q;
  assign col_cur  = restart_eff ? '0 : col_q;
  assign half_cur = restart_eff ? 1'b0 : half_q;
  assign rb_cur   = restart_eff ? IdxW'(1) : rb_q;

  assign col_inc    = LonW'(col_cur) + LonW'(1);
  assign at_row_end = (col_inc == lon_eff);
  assign col_nxt    = at_row_end ? '0 : ColW'(col_inc);

  assign lon_idx = IdxW'(lon_eff);
  assign col_idx = IdxW'(col_cur);
  assign nxt_idx = IdxW'(col_nxt);
  assign down    = rb_cur + lon_idx;

  always_comb begin
    tri_d    = '0;
    col_done = 1'b1;
    half_d   = half_cur;
    if (band_cur == '0) begin
      tri_d.index_first  = IdxW'(1) + col_idx;
      tri_d.index_second = '0;
      tri_d.index_third  = IdxW'(1) + nxt_idx;
    end else if (band_cur == south_band) begin
      tri_d.index_first  = rb_cur + col_idx;
      tri_d.index_second = rb_cur + nxt_idx;
      tri_d.index_third  = down;
    end else if (!half_cur) begin
      tri_d.index_first  = rb_cur + col_idx;
      tri_d.index_second = down + col_idx;
      tri_d.index_third  = rb_cur + nxt_idx;
      half_d             = 1'b1;
      col_done           = 1'b0;
    end else begin
      tri_d.index_first  = down + nxt_idx;
      tri_d.index_second = down + col_idx;
      tri_d.index_third  = rb_cur + nxt_idx;
      half_d             = 1'b0;
    end

    band_d = band_cur;
    col_d  = col_cur;
    rb_d   = rb_cur;
    if (col_done) begin
      if (at_row_end) begin
        if (band_cur >= south_band) begin
          tri_d.last_triangle = 1'b1;
          band_d = '0;
          col_d  = '0;
          half_d = 1'b0;
          rb_d   = IdxW'(1);
        end else begin
          if (band_cur != '0) begin
            rb_d = rb_cur + lon_idx;
          end
          band_d = band_cur + BandW'(1);
          col_d  = '0;
          half_d = 1'b0;
        end
      end else begin
        col_d = ColW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lon_cfg_q <= LonReset;
      lat_cfg_q <= LatReset;
      band_q    <= '0;
      col_q     <= '0;
      half_q    <= 1'b0;
      rb_q      <= IdxW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LONGITUDE: lon_cfg_q <= cfg_data_i;
        REG_LATITUDE:  lat_cfg_q <= cfg_data_i;
        default:       lon_cfg_q <= lon_cfg_q;
      endcase
      band_q <= '0;
      col_q  <= '0;
      half_q <= 1'b0;
      rb_q   <= IdxW'(1);
    end else if (acc) begin
      band_q <= band_d;
      col_q  <= col_d;
      half_q <= half_d;
      rb_q   <= rb_d;
    end
  end

  smig_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (buf_ready),
    .in_data_i   (tri_d),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (tri_out)
  );

  assign rsp_o.index_first   = tri_out.index_first;
  assign rsp_o.index_second  = tri_out.index_second;
  assign rsp_o.index_third   = tri_out.index_third;
  assign rsp_o.last_triangle = tri_out.last_triangle;

endmodule
